FILE: rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define PLOB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("plob assertion failed");

// Checked during reset as well.
`define PLOB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("plob assertion failed");

`endif

FILE: rtl/core/plob_pkg.sv
// ----------------------------------------------------------------------------
// plob_pkg
// Sizes, codes and record layouts for the price-level order book.
// ----------------------------------------------------------------------------
package plob_pkg;

  localparam int ORDER_SLOTS = 256;
  localparam int LEVEL_SLOTS = 64;
  localparam int OA_W        = $clog2(ORDER_SLOTS);
  localparam int LA_W        = $clog2(LEVEL_SLOTS);
  localparam int SCAN_MAX    = (ORDER_SLOTS > LEVEL_SLOTS) ? ORDER_SLOTS : LEVEL_SLOTS;
  localparam int SCAN_W      = $clog2(SCAN_MAX + 1);

  localparam int ID_W     = 64;
  localparam int PRICE_W  = 32;
  localparam int QTY_W    = 32;
  localparam int TOT_W    = 40;
  localparam int SPREAD_W = 33;
  localparam logic [TOT_W-1:0] TOT_MAX = '1;

  localparam int IN_TDATA_W  = 200;
  localparam int OUT_TDATA_W = 184;

  // output tdata field positions
  localparam int O_STATUS_LSB = 0;
  localparam int O_BBV_BIT    = 3;
  localparam int O_BB_LSB     = 4;
  localparam int O_BAV_BIT    = 36;
  localparam int O_BA_LSB     = 37;
  localparam int O_SPR_LSB    = 69;
  localparam int O_BVOL_LSB   = 102;
  localparam int O_AVOL_LSB   = 142;

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  typedef enum logic [1:0] {KIND_ADD, KIND_CANCEL, KIND_TICK, KIND_NONE} kind_t;

  typedef enum logic [2:0] {ST_OK, ST_DUP, ST_ZERO, ST_UNKNOWN, ST_FULL} status_t;

  typedef enum logic [2:0] {S_IDLE, S_OSCAN, S_LSCAN, S_WRITE, S_BEST, S_OUT} state_t;

  typedef struct packed {
    logic [QTY_W-1:0]   qty;
    logic [PRICE_W-1:0] price;
    logic               side;
    logic [ID_W-1:0]    id;
  } ord_ent_t;

  typedef struct packed {
    logic [TOT_W-1:0]   tot;
    logic [PRICE_W-1:0] price;
  } lvl_ent_t;

  // index SIDE_BID / SIDE_ASK
  typedef lvl_ent_t [1:0] lvl_row_t;

endpackage

FILE: rtl/core/plob_ram.sv
// ----------------------------------------------------------------------------
// plob_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module plob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/price_level_order_book.sv
// ----------------------------------------------------------------------------
// price_level_order_book
// Resting-order table with per-side price-level totals and book snapshot.
// ----------------------------------------------------------------------------
// Each transaction on the input gives one result. Orders live in a 256-entry
// RAM and price levels in a 64-row RAM (one bid and one ask level per row);
// valid bits sit in flops. Work is done by linear scans through a one-read
// port: an add or cancel walks the order RAM, then the level RAM, writes
// back and walks the levels again for best prices, then loads the output
// and returns to idle. An add or cancel rejected after the order walk, or
// an add rejected for a full level table, goes straight to the best-price
// walk; a market tick writes back first, and an unused kind only walks for
// best prices. One item is in work at a time; a new one is taken while the
// previous result still waits on the output.
module price_level_order_book (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // order_id, side, price, quantity, offer_price, offer_quantity, zero pad
  input  logic [plob_pkg::IN_TDATA_W-1:0]    in_tdata,
  // kind
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status, best_bid_valid, best_bid, best_ask_valid, best_ask, spread,
  // bid_volume, ask_volume, zero pad
  output logic [plob_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int OA_W   = plob_pkg::OA_W;
  localparam int LA_W   = plob_pkg::LA_W;
  localparam int SCAN_W = plob_pkg::SCAN_W;
  localparam int TOT_W  = plob_pkg::TOT_W;
  localparam int PW     = plob_pkg::PRICE_W;
  localparam int QW     = plob_pkg::QTY_W;
  localparam int LS     = plob_pkg::LEVEL_SLOTS;

  plob_pkg::state_t   state_r, state_nxt;
  plob_pkg::kind_t    kind_r;
  plob_pkg::status_t  status_r;
  logic [plob_pkg::ID_W-1:0] id_r;
  logic               side_r;
  logic [PW-1:0]      price_r, ap_r;
  logic [QW-1:0]      qty_r, aq_r;

  logic [SCAN_W-1:0]  cnt_r, pidx_r, scan_lim;
  logic               pv_r, issue, scan_done;

  logic               dup_r, ofree_v_r;
  logic [OA_W-1:0]    ofree_idx_r, ofound_idx_r;
  plob_pkg::ord_ent_t ofound_ent_r;

  logic               tgt_side_r;
  logic [PW-1:0]      tgt_price_r;
  logic               lm_v_r, lf_v_r;
  logic [LA_W-1:0]    lm_idx_r, lf_idx_r;
  plob_pkg::lvl_row_t lm_row_r, lf_row_r;

  logic [plob_pkg::ORDER_SLOTS-1:0]        slot_used_r;
  logic [1:0][plob_pkg::LEVEL_SLOTS-1:0]   lvl_used_r;
  logic [1:0][TOT_W-1:0]                   tot_r;

  logic               bv_r, av_r;
  logic [PW-1:0]      bb_r, ba_r;
  logic               out_valid_r;
  logic [plob_pkg::OUT_TDATA_W-1:0] out_data_r;

  // RAM ports
  logic                ord_we;
  logic [OA_W-1:0]     ord_waddr;
  plob_pkg::ord_ent_t  ord_wdata, ord_rdata;
  logic                lvl_we;
  logic [LA_W-1:0]     lvl_waddr;
  plob_pkg::lvl_row_t  lvl_wdata, lvl_rdata;

  logic in_fire, out_load;

  // decisions at the end of scans
  logic               o_go_lscan;
  plob_pkg::status_t  o_status;
  logic               o_tside;
  logic [PW-1:0]      o_tprice;
  logic               l_full;

  // write-back datapath
  logic [LA_W-1:0]    w_idx;
  plob_pkg::lvl_row_t w_row_sel;
  plob_pkg::lvl_ent_t w_ent;
  logic [TOT_W-1:0]   w_before, w_newtot, w_addamt, w_take, w_side_tot, w_qext;
  logic [TOT_W:0]     w_sum, w_sum2;

  plob_ram #(.WIDTH($bits(plob_pkg::ord_ent_t)), .DEPTH(plob_pkg::ORDER_SLOTS)) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (cnt_r[OA_W-1:0]),
    .rdata (ord_rdata)
  );

  plob_ram #(.WIDTH($bits(plob_pkg::lvl_row_t)), .DEPTH(plob_pkg::LEVEL_SLOTS)) u_lvl_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (lvl_waddr),
    .wdata (lvl_wdata),
    .raddr (cnt_r[LA_W-1:0]),
    .rdata (lvl_rdata)
  );

  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == plob_pkg::S_OUT) && (!out_valid_r || out_tready);
  assign scan_lim  = (state_r == plob_pkg::S_OSCAN) ? SCAN_W'(plob_pkg::ORDER_SLOTS)
                                                    : SCAN_W'(plob_pkg::LEVEL_SLOTS);
  assign issue     = cnt_r < scan_lim;
  assign scan_done = !issue && !pv_r;

  always_comb begin
    o_go_lscan = 1'b0;
    o_status   = plob_pkg::ST_OK;
    o_tside    = side_r;
    o_tprice   = price_r;
    if (kind_r == plob_pkg::KIND_ADD) begin
      if (dup_r) begin
        o_status = plob_pkg::ST_DUP;
      end else if (qty_r == '0 || price_r == '0) begin
        o_status = plob_pkg::ST_ZERO;
      end else if (!ofree_v_r) begin
        o_status = plob_pkg::ST_FULL;
      end else begin
        o_go_lscan = 1'b1;
      end
    end else begin
      if (!dup_r) begin
        o_status = plob_pkg::ST_UNKNOWN;
      end else begin
        o_go_lscan = 1'b1;
        o_tside    = ofound_ent_r.side;
        o_tprice   = ofound_ent_r.price;
      end
    end
  end

  assign l_full = (kind_r == plob_pkg::KIND_ADD) && !lm_v_r && !lf_v_r;

  // write-back arithmetic
  always_comb begin
    w_idx      = lm_v_r ? lm_idx_r : lf_idx_r;
    w_row_sel  = lm_v_r ? lm_row_r : lf_row_r;
    w_ent      = w_row_sel[tgt_side_r];
    w_before   = lm_v_r ? w_ent.tot : '0;
    w_side_tot = tot_r[tgt_side_r];
    w_qext     = (kind_r == plob_pkg::KIND_ADD) ? TOT_W'(qty_r) : TOT_W'(ofound_ent_r.qty);
    w_sum      = {1'b0, w_before} + {1'b0, w_qext};
    w_take     = (w_qext > w_before) ? w_before : w_qext;
    if (kind_r == plob_pkg::KIND_ADD) begin
      w_newtot = w_sum[TOT_W] ? plob_pkg::TOT_MAX : w_sum[TOT_W-1:0];
    end else begin
      w_newtot = w_before - w_take;
    end
    w_addamt = w_newtot - w_before;
    w_sum2   = {1'b0, w_side_tot} + {1'b0, w_addamt};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plob_pkg::S_IDLE: begin
        if (in_fire) begin
          case (plob_pkg::kind_t'(in_tuser))
            plob_pkg::KIND_ADD, plob_pkg::KIND_CANCEL: state_nxt = plob_pkg::S_OSCAN;
            plob_pkg::KIND_TICK:                      state_nxt = plob_pkg::S_WRITE;
            default:                                  state_nxt = plob_pkg::S_BEST;
          endcase
        end
      end
      plob_pkg::S_OSCAN: begin
        if (scan_done) begin
          state_nxt = o_go_lscan ? plob_pkg::S_LSCAN : plob_pkg::S_BEST;
        end
      end
      plob_pkg::S_LSCAN: begin
        if (scan_done) begin
          state_nxt = l_full ? plob_pkg::S_BEST : plob_pkg::S_WRITE;
        end
      end
      plob_pkg::S_WRITE: state_nxt = plob_pkg::S_BEST;
      plob_pkg::S_BEST: begin
        if (scan_done) begin
          state_nxt = plob_pkg::S_OUT;
        end
      end
      plob_pkg::S_OUT: begin
        if (out_load) begin
          state_nxt = plob_pkg::S_IDLE;
        end
      end
      default: state_nxt = plob_pkg::S_IDLE;
    endcase
  end

  // control outputs: handshake and RAM writes
  always_comb begin
    in_tready = (state_r == plob_pkg::S_IDLE);
    ord_we    = 1'b0;
    ord_waddr = ofree_idx_r;
    ord_wdata = '{qty: qty_r, price: price_r, side: side_r, id: id_r};
    lvl_we    = 1'b0;
    lvl_waddr = w_idx;
    lvl_wdata = w_row_sel;
    lvl_wdata[tgt_side_r].tot   = w_newtot;
    lvl_wdata[tgt_side_r].price = tgt_price_r;
    if (state_r == plob_pkg::S_WRITE) begin
      case (kind_r)
        plob_pkg::KIND_ADD: begin
          ord_we = 1'b1;
          lvl_we = 1'b1;
        end
        plob_pkg::KIND_CANCEL: begin
          lvl_we = lm_v_r;
        end
        plob_pkg::KIND_TICK: begin
          lvl_we    = 1'b1;
          lvl_waddr = '0;
          lvl_wdata[plob_pkg::SIDE_BID] = '{tot: TOT_W'(qty_r), price: price_r};
          lvl_wdata[plob_pkg::SIDE_ASK] = '{tot: TOT_W'(aq_r), price: ap_r};
        end
        default: lvl_we = 1'b0;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plob_pkg::S_IDLE;
      slot_used_r <= '0;
      lvl_used_r  <= '0;
      tot_r       <= '0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;

      if (state_nxt != state_r) begin
        cnt_r <= '0;
        pv_r  <= 1'b0;
      end else if (state_r == plob_pkg::S_OSCAN || state_r == plob_pkg::S_LSCAN ||
                   state_r == plob_pkg::S_BEST) begin
        pv_r <= issue;
        if (issue) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end

      if (state_r == plob_pkg::S_WRITE) begin
        case (kind_r)
          plob_pkg::KIND_ADD: begin
            slot_used_r[ofree_idx_r]       <= 1'b1;
            lvl_used_r[tgt_side_r][w_idx]  <= 1'b1;
            tot_r[tgt_side_r] <= w_sum2[TOT_W] ? plob_pkg::TOT_MAX : w_sum2[TOT_W-1:0];
          end
          plob_pkg::KIND_CANCEL: begin
            slot_used_r[ofound_idx_r] <= 1'b0;
            if (lm_v_r) begin
              tot_r[tgt_side_r] <= (w_take > w_side_tot) ? '0 : w_side_tot - w_take;
              if (w_newtot == '0) begin
                lvl_used_r[tgt_side_r][w_idx] <= 1'b0;
              end
            end
          end
          plob_pkg::KIND_TICK: begin
            // only level 0 stays on each side
            lvl_used_r <= {2{LS'(1)}};
            tot_r[plob_pkg::SIDE_BID] <= TOT_W'(qty_r);
            tot_r[plob_pkg::SIDE_ASK] <= TOT_W'(aq_r);
          end
          default: tot_r <= tot_r;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pidx_r <= cnt_r;

    if (in_fire) begin
      kind_r    <= plob_pkg::kind_t'(in_tuser);
      id_r      <= in_tdata[63:0];
      side_r    <= in_tdata[64];
      price_r   <= in_tdata[96:65];
      qty_r     <= in_tdata[128:97];
      ap_r      <= in_tdata[160:129];
      aq_r      <= in_tdata[192:161];
      status_r  <= plob_pkg::ST_OK;
      dup_r     <= 1'b0;
      ofree_v_r <= 1'b0;
    end

    if (state_r == plob_pkg::S_OSCAN) begin
      if (pv_r) begin
        if (slot_used_r[pidx_r[OA_W-1:0]] && ord_rdata.id == id_r) begin
          dup_r        <= 1'b1;
          ofound_idx_r <= pidx_r[OA_W-1:0];
          ofound_ent_r <= ord_rdata;
        end
        if (!slot_used_r[pidx_r[OA_W-1:0]] && !ofree_v_r) begin
          ofree_v_r   <= 1'b1;
          ofree_idx_r <= pidx_r[OA_W-1:0];
        end
      end
      if (scan_done) begin
        status_r    <= o_status;
        tgt_side_r  <= o_tside;
        tgt_price_r <= o_tprice;
        lm_v_r      <= 1'b0;
        lf_v_r      <= 1'b0;
      end
    end

    if (state_r == plob_pkg::S_LSCAN) begin
      if (pv_r) begin
        if (lvl_used_r[tgt_side_r][pidx_r[LA_W-1:0]] &&
            lvl_rdata[tgt_side_r].price == tgt_price_r) begin
          lm_v_r   <= 1'b1;
          lm_idx_r <= pidx_r[LA_W-1:0];
          lm_row_r <= lvl_rdata;
        end
        if (!lvl_used_r[tgt_side_r][pidx_r[LA_W-1:0]] && !lf_v_r) begin
          lf_v_r   <= 1'b1;
          lf_idx_r <= pidx_r[LA_W-1:0];
          lf_row_r <= lvl_rdata;
        end
      end
      if (scan_done && l_full) begin
        status_r <= plob_pkg::ST_FULL;
      end
    end

    if (state_nxt == plob_pkg::S_BEST && state_r != plob_pkg::S_BEST) begin
      bv_r <= 1'b0;
      av_r <= 1'b0;
      bb_r <= '0;
      ba_r <= '0;
    end else if (state_r == plob_pkg::S_BEST && pv_r) begin
      if (lvl_used_r[plob_pkg::SIDE_BID][pidx_r[LA_W-1:0]] &&
          (!bv_r || lvl_rdata[plob_pkg::SIDE_BID].price > bb_r)) begin
        bv_r <= 1'b1;
        bb_r <= lvl_rdata[plob_pkg::SIDE_BID].price;
      end
      if (lvl_used_r[plob_pkg::SIDE_ASK][pidx_r[LA_W-1:0]] &&
          (!av_r || lvl_rdata[plob_pkg::SIDE_ASK].price < ba_r)) begin
        av_r <= 1'b1;
        ba_r <= lvl_rdata[plob_pkg::SIDE_ASK].price;
      end
    end

    if (out_load) begin
      out_data_r <= {2'b00,
                     tot_r[plob_pkg::SIDE_ASK],
                     tot_r[plob_pkg::SIDE_BID],
                     ((bv_r && av_r) ? ({1'b0, ba_r} - {1'b0, bb_r})
                                     : {plob_pkg::SPREAD_W{1'b0}}),
                     ba_r, av_r, bb_r, bv_r, status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/core/plob_checker.sv
// ----------------------------------------------------------------------------
// plob_checker
// Port-level checks on the result stream of the order book.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plob_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [plob_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic [2:0] st;
  logic       bbv, bav;
  logic [plob_pkg::SPREAD_W-1:0] spr;

  assign st  = out_tdata[plob_pkg::O_STATUS_LSB +: 3];
  assign bbv = out_tdata[plob_pkg::O_BBV_BIT];
  assign bav = out_tdata[plob_pkg::O_BAV_BIT];
  assign spr = out_tdata[plob_pkg::O_SPR_LSB +: plob_pkg::SPREAD_W];

  // stalled result keeps its data
  `PLOB_ASSERT(a_hold, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata))
  // nothing is offered right after reset
  `PLOB_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_tvalid)
  // status never beyond table full
  `PLOB_ASSERT(a_status, clk, rst_n, out_tvalid |-> st <= plob_pkg::ST_FULL)
  // an empty side forces a zero spread
  `PLOB_ASSERT(a_spread, clk, rst_n, out_tvalid && (!bbv || !bav) |-> spr == '0)

endmodule

bind price_level_order_book plob_checker u_plob_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
